[rtl/lpht_pkg.sv]
package lpht_pkg;

    localparam int DEFAULT_SLOTS = 256;
    localparam int OP_W          = 2;
    localparam int KEY_W         = 32;
    localparam int HASH_W        = 32;
    localparam int VAL_W         = 64;
    localparam int STAT_W        = 2;

    localparam logic [OP_W-1:0] OP_GET = 2'd0;
    localparam logic [OP_W-1:0] OP_SET = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_TOMB  = 2'd1;
    localparam logic [1:0] ST_USED  = 2'd2;

    typedef struct packed {
        logic [1:0]       st;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } slot_t;

endpackage

[rtl/linear_probe_hash_table_top.sv]
// flow: start goes straight to S_PROBE for power-of-two SLOTS, through S_MOD and S_FOLD otherwise;
//   S_PROBE then checks P slots (one slot per cycle, at most SLOTS) before done
// one item at a time; start is taken again in the cycle done shows
// done is high for one cycle, the result held until the next; the receiver cannot stall
// reset: asynchronous, active low; afterwards a clearing pass marks every slot empty,
//   with busy high throughout
module linear_probe_hash_table_top #(
    parameter int SLOTS = lpht_pkg::DEFAULT_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lpht_pkg::OP_W-1:0]   operation,
    input  logic [lpht_pkg::KEY_W-1:0]  key_id,
    input  logic [lpht_pkg::HASH_W-1:0] key_hash,
    input  logic [lpht_pkg::VAL_W-1:0]  value,
    output logic                        busy,
    output logic                        done,
    output logic [lpht_pkg::STAT_W-1:0] status,
    output logic                        is_new,
    output logic [lpht_pkg::VAL_W-1:0]  found_value
);

    import lpht_pkg::*;

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int LIMIT = (SLOTS * 3) / 4;
    localparam bit POW2  = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int SHIFT = HASH_W + IW;

    localparam logic [63:0] MAGIC_W = ((64'd1 << SHIFT) + 64'(SLOTS - 1)) / 64'(SLOTS);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;

    slot_t mem [SLOTS];
    slot_t rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     quot_reg, quot_next;
    logic              have_tomb_reg, have_tomb_next;
    logic [IW-1:0]     tomb_reg, tomb_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              is_new_reg, is_new_next;
    logic [VAL_W-1:0]  found_reg, found_next;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    slot_t             wr_data;

    logic [2*HASH_W:0] prod;
    logic              hit_empty, hit_key, is_tomb, last, fin, ok, have_t;
    logic [IW-1:0]     tomb_i, tgt, nxt;
    logic [1:0]        tgt_st;

    // slot store, registered read at the next probe address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[cur_next];
    end

    always_comb
    begin
        prod = {{(HASH_W + 1){1'b0}}, hash_reg} * {{HASH_W{1'b0}}, MAGIC_W[HASH_W:0]};

        hit_empty = (rd_data_reg.st == ST_EMPTY);
        hit_key   = (rd_data_reg.st == ST_USED) && (rd_data_reg.key == key_reg);
        is_tomb   = (rd_data_reg.st == ST_TOMB);
        have_t    = have_tomb_reg || is_tomb;
        tomb_i    = have_tomb_reg ? tomb_reg : cur_reg;
        last      = (cnt_reg == IW'(SLOTS - 1));
        fin       = hit_empty || hit_key || last;
        nxt       = (cur_reg == IW'(SLOTS - 1)) ? '0 : cur_reg + 1'b1;

        if (hit_key)
        begin
            ok     = 1'b1;
            tgt    = cur_reg;
            tgt_st = ST_USED;
        end
        else if (hit_empty)
        begin
            ok     = 1'b1;
            tgt    = have_tomb_reg ? tomb_reg : cur_reg;
            tgt_st = have_tomb_reg ? ST_TOMB : ST_EMPTY;
        end
        else
        begin
            ok     = have_t;
            tgt    = tomb_i;
            tgt_st = ST_TOMB;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        quot_next      = quot_reg;
        have_tomb_next = have_tomb_reg;
        tomb_next      = tomb_reg;
        used_next      = used_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        val_next       = val_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        is_new_next    = is_new_reg;
        found_next     = found_reg;
        wr_en          = 1'b0;
        wr_addr        = tgt;
        wr_data        = slot_t'{st: ST_USED, key: key_reg, val: val_reg};

        unique case (state_reg)
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = slot_t'{st: ST_EMPTY, key: '0, val: '0};
                if (clr_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next        = operation;
                    key_next       = key_id;
                    hash_next      = key_hash;
                    val_next       = value;
                    have_tomb_next = 1'b0;
                    cnt_next       = '0;
                    if (POW2)
                    begin
                        cur_next   = key_hash[IW-1:0];
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                // quotient by reciprocal multiplication, low bits only
                quot_next  = prod[SHIFT +: IW];
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                // remainder fits in the low index bits
                cur_next   = hash_reg[IW-1:0] - quot_reg * IW'(SLOTS);
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (!fin)
                begin
                    have_tomb_next = have_t;
                    tomb_next      = tomb_i;
                    cnt_next       = cnt_reg + 1'b1;
                    cur_next       = nxt;
                end
                else
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = STAT_NOT_FOUND;
                    is_new_next = 1'b0;
                    found_next  = '0;
                    if (op_reg == OP_SET)
                    begin
                        if (!ok || (tgt_st == ST_EMPTY && used_reg >= CW'(LIMIT)))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            status_next = STAT_DONE;
                            wr_en       = 1'b1;
                            is_new_next = (tgt_st != ST_USED);
                            if (tgt_st == ST_EMPTY)
                            begin
                                used_next = used_reg + 1'b1;
                            end
                        end
                    end
                    else if ((op_reg == OP_GET || op_reg == OP_DEL) && ok
                             && tgt_st == ST_USED)
                    begin
                        status_next = STAT_DONE;
                        if (op_reg == OP_GET)
                        begin
                            found_next = rd_data_reg.val;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = slot_t'{st: ST_TOMB, key: '0, val: '0};
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            used_reg      <= '0;
            done_reg      <= 1'b0;
            have_tomb_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            done_reg      <= done_next;
            have_tomb_reg <= have_tomb_next;
            cnt_reg       <= cnt_next;
        end
    end

    // item payload and result registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        quot_reg   <= quot_next;
        tomb_reg   <= tomb_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        hash_reg   <= hash_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        is_new_reg <= is_new_next;
        found_reg  <= found_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign is_new      = is_new_reg;
    assign found_value = found_reg;

`ifndef ASSERT_OFF
    a_done_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_PROBE))
        else $error("result strobe without a finished probe");

    a_used_limit: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(LIMIT))
        else $error("used count beyond load limit");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STAT_FULL) |-> (!is_new_reg && found_reg == '0))
        else $error("refused set with stray result fields");

    a_new_only_on_set: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && is_new_reg) |-> (op_reg == OP_SET && status_reg == STAT_DONE))
        else $error("new key flag outside a completed set");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

    import lpht_pkg::*;

    localparam int SLOTS      = DEFAULT_SLOTS;
    localparam int LOAD_LIMIT = SLOTS * 3 / 4;
    localparam int POOL       = 320;
    localparam int CHUNK      = 40;
    localparam int TAIL       = 2 * SLOTS + 40;
    localparam int WDOG_LIMIT = 4000;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [VAL_W-1:0]  val;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              is_new;
        logic [VAL_W-1:0]  found;
    } result_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic [OP_W-1:0]   operation   = '0;
    logic [KEY_W-1:0]  key_id      = '0;
    logic [HASH_W-1:0] key_hash    = '0;
    logic [VAL_W-1:0]  value       = '0;
    logic              busy;
    logic              done;
    logic [STAT_W-1:0] status;
    logic              is_new;
    logic [VAL_W-1:0]  found_value;

    linear_probe_hash_table_top #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .key_id     (key_id),
        .key_hash   (key_hash),
        .value      (value),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .is_new     (is_new),
        .found_value(found_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    request_t         pending_q[$];
    result_t          expected_q[$];
    request_t         cur;
    int               gap_pct     = 0;
    int               error_count = 0;
    int               idle_cycles = 0;

    logic [1:0]       tbl_st  [SLOTS];
    logic [KEY_W-1:0] tbl_key [SLOTS];
    logic [VAL_W-1:0] tbl_val [SLOTS];
    int               tbl_used;

    logic [KEY_W-1:0]  pool_key  [POOL];
    logic [HASH_W-1:0] pool_hash [POOL];

    int n_ops [4];
    int n_new, n_reuse, n_over, n_full, n_missing;

    task automatic report_error(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic result_t apply_request(input request_t rq);
        result_t r;
        int      idx;
        int      tomb;
        int      slot;
        int      n;
        bit      have_tomb;
        bit      hit;
        r.status  = STAT_NOT_FOUND;
        r.is_new  = 1'b0;
        r.found   = '0;
        n_ops[rq.op]++;
        if (rq.op == OP_GET || rq.op == OP_SET || rq.op == OP_DEL)
        begin
            idx       = int'(rq.hash % SLOTS);
            have_tomb = 1'b0;
            hit       = 1'b0;
            tomb      = 0;
            slot      = 0;
            n         = 0;
            while (!hit && n < SLOTS)
            begin
                if (tbl_st[idx] == ST_EMPTY)
                begin
                    slot = have_tomb ? tomb : idx;
                    hit  = 1'b1;
                end
                else
                begin
                    if (tbl_st[idx] == ST_USED && tbl_key[idx] == rq.key)
                    begin
                        slot = idx;
                        hit  = 1'b1;
                    end
                    else if (tbl_st[idx] == ST_TOMB && !have_tomb)
                    begin
                        have_tomb = 1'b1;
                        tomb      = idx;
                    end
                    idx = (idx + 1) % SLOTS;
                    n++;
                end
            end
            if (!hit)
            begin
                slot = tomb;
                hit  = have_tomb;
            end
            if (rq.op == OP_SET)
            begin
                if (!hit || (tbl_st[slot] == ST_EMPTY && tbl_used + 1 > LOAD_LIMIT))
                begin
                    r.status = STAT_FULL;
                    n_full++;
                end
                else
                begin
                    if (tbl_st[slot] == ST_EMPTY)
                    begin
                        r.is_new = 1'b1;
                        tbl_used++;
                        n_new++;
                    end
                    else if (tbl_st[slot] == ST_TOMB)
                    begin
                        r.is_new = 1'b1;
                        n_reuse++;
                    end
                    else
                        n_over++;
                    tbl_st[slot]  = ST_USED;
                    tbl_key[slot] = rq.key;
                    tbl_val[slot] = rq.val;
                    r.status      = STAT_DONE;
                end
            end
            else if (hit && tbl_st[slot] == ST_USED)
            begin
                r.status = STAT_DONE;
                if (rq.op == OP_GET)
                    r.found = tbl_val[slot];
                else
                begin
                    tbl_st[slot]  = ST_TOMB;
                    tbl_key[slot] = '0;
                    tbl_val[slot] = '0;
                end
            end
        end
        if (r.status == STAT_NOT_FOUND)
            n_missing++;
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin : drive_requests
        request_t nxt;
        bit       taken;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            if (taken)
                expected_q.push_back(apply_request(cur));
            if (!start || taken)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= gap_pct)
                begin
                    nxt       = pending_q.pop_front();
                    cur       = nxt;
                    operation <= nxt.op;
                    key_id    <= nxt.key;
                    key_hash  <= nxt.hash;
                    value     <= nxt.val;
                    start     <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
                report_error("result with no request outstanding");
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.status)
                    report_error($sformatf("status %0d, expected %0d", status, want.status));
                if (is_new !== want.is_new)
                    report_error($sformatf("is_new %0b, expected %0b", is_new, want.is_new));
                if (found_value !== want.found)
                    report_error($sformatf("found_value %h, expected %h",
                                           found_value, want.found));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("timeout: no activity for %0d cycles", WDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [HASH_W-1:0] hash, input logic [VAL_W-1:0] val);
        request_t rq;
        rq.op   = op;
        rq.key  = key;
        rq.hash = hash;
        rq.val  = val;
        pending_q.push_back(rq);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || start || expected_q.size() != 0);
    endtask

    task automatic queue_random(input int count);
        int               k;
        int               pick;
        int               noise;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [HASH_W-1:0] hash;
        for (int i = 0; i < count; i++)
        begin
            k     = $urandom_range(POOL - 1);
            pick  = $urandom_range(99);
            noise = $urandom_range(99);
            key   = pool_key[k];
            hash  = pool_hash[k];
            if (pick < 45)
                op = OP_SET;
            else if (pick < 75)
                op = OP_GET;
            else if (pick < 95)
                op = OP_DEL;
            else
                op = OP_UNKNOWN;
            // stray keys and keys under the wrong hash
            if (noise < 6)
            begin
                key  = $urandom;
                hash = $urandom;
            end
            else if (noise < 10)
                hash = $urandom;
            push_request(op, key, hash, {$urandom, $urandom});
        end
    endtask

    initial
    begin : stimulus
        logic [HASH_W-1:0] h;
        int                phase_gap;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_st[i]  = ST_EMPTY;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        tbl_used = 0;
        for (int i = 0; i < 4; i++)
            n_ops[i] = 0;
        n_new = 0; n_reuse = 0; n_over = 0; n_full = 0; n_missing = 0;
        for (int i = 0; i < POOL; i++)
        begin
            pool_key[i] = $urandom;
            h           = $urandom;
            // crowd a third of the keys into a narrow band of slots
            if ($urandom_range(2) == 0)
                h[7:0] = 8'($urandom_range(63));
            pool_hash[i] = h;
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        push_request(OP_GET,     32'h0000_1111, 32'h0000_0005, 64'h0);
        push_request(OP_DEL,     32'h0000_1111, 32'h0000_0005, 64'h0);
        push_request(OP_SET,     32'h0000_1111, 32'h0000_0005, '1);
        push_request(OP_GET,     32'h0000_1111, 32'h0000_0005, 64'h0);
        push_request(OP_SET,     32'h0000_1111, 32'h0000_0005, 64'h0);
        push_request(OP_GET,     32'h0000_1111, 32'h0000_0005, '1);
        push_request(OP_SET,     32'hFFFF_FFFF, 32'hFFFF_FF05, 64'h0123_4567_89AB_CDEF);
        push_request(OP_SET,     32'h0000_0000, 32'h0000_0005, 64'hFEDC_BA98_7654_3210);
        push_request(OP_DEL,     32'hFFFF_FFFF, 32'hFFFF_FF05, 64'h0);
        push_request(OP_GET,     32'h0000_0000, 32'h0000_0005, 64'h0);
        push_request(OP_SET,     32'h0000_2222, 32'h0000_0105, 64'h5555_5555_5555_5555);
        push_request(OP_SET,     32'hFFFF_FFFF, 32'hFFFF_FF05, 64'hAAAA_AAAA_AAAA_AAAA);
        push_request(OP_GET,     32'hFFFF_FFFF, 32'hFFFF_FF05, 64'h0);
        push_request(OP_UNKNOWN, 32'h0000_1111, 32'h0000_0005, '1);
        push_request(OP_SET,     32'h0000_3333, 32'hFFFF_FFFF, 64'h1);
        push_request(OP_SET,     32'h0000_4444, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
        push_request(OP_GET,     32'h0000_4444, 32'hFFFF_FFFF, 64'h0);
        push_request(OP_DEL,     32'h0000_3333, 32'hFFFF_FFFF, 64'h0);
        push_request(OP_GET,     32'h0000_4444, 32'hFFFF_FFFF, '1);
        push_request(OP_DEL,     32'h0000_4444, 32'hFFFF_FFFF, 64'h0);
        push_request(OP_DEL,     32'h0000_4444, 32'hFFFF_FFFF, 64'h0);
        push_request(OP_GET,     32'h0000_4444, 32'h0000_0000, 64'h0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       phase_gap = 87;
                3:       phase_gap = 15;
                default: phase_gap = 0;
            endcase
            for (int c = 0; c < 9; c++)
            begin
                gap_pct = ($urandom_range(3) == 0) ? 0 : phase_gap;
                queue_random(CHUNK);
                while (pending_q.size() != 0)
                    @(negedge clk);
            end
            // let the table settle before the next phase
            wait_drained();
        end
        gap_pct = 0;

        repeat (TAIL) @(negedge clk);
        if (expected_q.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_q.size()));

        $display("covered %0d get, %0d set, %0d delete and %0d unknown requests",
                 n_ops[OP_GET], n_ops[OP_SET], n_ops[OP_DEL], n_ops[OP_UNKNOWN]);
        $display("new keys %0d, tombstones reused %0d, overwrites %0d, refused %0d, misses %0d",
                 n_new, n_reuse, n_over, n_full, n_missing);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
rtl/lpht_pkg.sv
rtl/linear_probe_hash_table_top.sv
dv/tb.sv
